// ===== rtl/core/amdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared types and constants of the adjacency matrix depth-first search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package amdfs_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_STACK_DEPTH  = 4096;

   localparam int CMD_W    = 2;
   localparam int VERTEX_W = 7;

   localparam logic [VERTEX_W-1:0] VCOUNT_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_ADD_EDGE = 2'd1,
      CMD_SEARCH   = 2'd2
   } cmd_type;

   // control from the search sequencer to the matrix store
   typedef struct packed {
      logic clear;
      logic rd_en;
      logic wr_en;
   } adj_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/core/amdfs_adj_store.sv =====
// ----------------------------------------------------------------------------
// amdfs_adj_store
// Adjacency matrix memory, one row per source vertex, with per-row valid bits
// so that a clear of the whole matrix resets only the valid bits, not the rows.
// ----------------------------------------------------------------------------
`default_nettype none

module amdfs_adj_store
   import amdfs_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   localparam int VIDX_W      = $clog2(MAX_VERTICES)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire adj_ctl_type             ctl,
   input  wire logic [VIDX_W-1:0]       addr,
   input  wire logic [MAX_VERTICES-1:0] wdata,
   output logic      [MAX_VERTICES-1:0] rdata
);

   logic [MAX_VERTICES-1:0] row_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_vld_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         row_mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= row_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (ctl.clear) begin
            row_vld_ff <= '0;
         end else if (ctl.wr_en) begin
            row_vld_ff[addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= row_vld_ff[addr];
         end
      end
   end

   // a row never written since the last clear reads as empty
   assign rdata = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/core/adjacency_matrix_dfs_engine.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_engine
// Directed graph held as an adjacency bit matrix; clear, add edge and
// explicit-stack depth-first search emitting vertices in visit order.
// ----------------------------------------------------------------------------
// one command at a time, taken in idle: clear resets the row valid bits, add edge is a row read then a write back
// search: each stack pop reads the stack (ST_POP, then ST_POP_WAIT) and, for each newly visited
// vertex, its row is read and then scanned over the active vertex count, pushing unvisited
// neighbours; the search stalls while a result waits; each visit leaves when the
// next is found, the last one after the stack runs empty
// reset is synchronous: rows read empty via their valid bits at once, vertex count 64
`default_nettype none

module adjacency_matrix_dfs_engine
   import amdfs_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int STACK_DEPTH  = DEF_STACK_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // command stream
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,  // command[1:0], src_vertex[8:2], dst_vertex[15:9]
   // visited vertex stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [7:0]          rsp_tdata,  // visited_vertex[6:0], zero[7]
   output logic                     rsp_tlast,  // last_visit
   output logic                     rsp_tuser,  // stack_overflow
   // vertex count register
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [VERTEX_W-1:0] csr_data
);

   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int FILL_W = $clog2(STACK_DEPTH + 1);
   localparam logic [VERTEX_W-1:0] MAXV_V    = VERTEX_W'(MAX_VERTICES);
   localparam logic [FILL_W-1:0]   FILL_FULL = FILL_W'(STACK_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_WR,
      ST_POP,
      ST_POP_WAIT,
      ST_VISIT,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [VERTEX_W-1:0]     vcount_ff, vcount_in;
   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic                    ovf_ff, ovf_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [VIDX_W-1:0]       scan_ff, scan_in;
   logic [MAX_VERTICES-1:0] row_ff, row_in;
   logic [VIDX_W-1:0]       cur_ff, cur_in;
   logic [VIDX_W-1:0]       dst_ff, dst_in;
   logic                    held_vld_ff, held_vld_in;
   logic [VIDX_W-1:0]       held_vtx_ff, held_vtx_in;
   logic                    held_ovf_ff, held_ovf_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [VERTEX_W-1:0]     rsp_vtx_ff, rsp_vtx_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   // stack memory
   logic [VIDX_W-1:0] stk_mem [STACK_DEPTH];
   logic [VIDX_W-1:0] stk_rd_ff;
   logic              stk_we, stk_re;
   logic [SP_W-1:0]   stk_waddr, stk_raddr;
   logic [VIDX_W-1:0] stk_wdata;
   logic [FILL_W-1:0] fill_dec;

   // matrix store
   adj_ctl_type             adj_ctl;
   logic [VIDX_W-1:0]       adj_addr;
   logic [MAX_VERTICES-1:0] adj_wdata;
   logic [MAX_VERTICES-1:0] adj_row;

   // decoded request
   cmd_type             req_cmd;
   logic [VERTEX_W-1:0] req_src, req_dst;
   logic [VERTEX_W-1:0] n_active;
   logic                src_ok, dst_ok;
   logic [VIDX_W-1:0]   src_idx, dst_idx;
   logic                req_xfer, out_free;

   assign req_cmd  = cmd_type'(req_tdata[1:0]);
   assign req_src  = req_tdata[8:2];
   assign req_dst  = req_tdata[15:9];
   assign n_active = (vcount_ff > MAXV_V) ? MAXV_V : vcount_ff;
   assign src_ok   = (req_src != '0) && (req_src <= n_active);
   assign dst_ok   = (req_dst != '0) && (req_dst <= n_active);
   assign src_idx  = VIDX_W'(req_src - VERTEX_W'(1));
   assign dst_idx  = VIDX_W'(req_dst - VERTEX_W'(1));
   assign fill_dec = fill_ff - FILL_W'(1);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_vtx_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   amdfs_adj_store #(
      .MAX_VERTICES(MAX_VERTICES)
   ) u_adj_store (
      .clock (clock),
      .reset (reset),
      .ctl   (adj_ctl),
      .addr  (adj_addr),
      .wdata (adj_wdata),
      .rdata (adj_row)
   );

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   always_comb begin
      state_in    = state_ff;
      vcount_in   = vcount_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      visited_in  = visited_ff;
      scan_in     = scan_ff;
      row_in      = row_ff;
      cur_in      = cur_ff;
      dst_in      = dst_ff;
      held_vld_in = held_vld_ff;
      held_vtx_in = held_vtx_ff;
      held_ovf_in = held_ovf_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_vtx_in  = rsp_vtx_ff;
      rsp_last_in = rsp_last_ff;
      rsp_ovf_in  = rsp_ovf_ff;

      adj_ctl   = '0;
      adj_addr  = cur_ff;
      adj_wdata = adj_row | (MAX_VERTICES'(1) << dst_ff);

      stk_we    = 1'b0;
      stk_waddr = fill_ff[SP_W-1:0];
      stk_wdata = scan_ff;
      stk_re    = 1'b0;
      stk_raddr = fill_dec[SP_W-1:0];

      if (csr_valid && csr_ready) begin
         vcount_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     adj_ctl.clear = 1'b1;
                  end
                  CMD_ADD_EDGE: begin
                     if (src_ok && dst_ok) begin
                        adj_ctl.rd_en = 1'b1;
                        adj_addr      = src_idx;
                        cur_in        = src_idx;
                        dst_in        = dst_idx;
                        state_in      = ST_ADD_WR;
                     end
                  end
                  CMD_SEARCH: begin
                     visited_in  = '0;
                     ovf_in      = 1'b0;
                     held_vld_in = 1'b0;
                     if (src_ok) begin
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = src_idx;
                        fill_in   = FILL_W'(1);
                        state_in  = ST_POP;
                     end else begin
                        fill_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_WR: begin
            adj_ctl.wr_en = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_POP: begin
            if (fill_ff == '0) begin
               state_in = ST_FLUSH;
            end else begin
               stk_re   = 1'b1;
               fill_in  = fill_dec;
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            if (visited_ff[stk_rd_ff]) begin
               state_in = ST_POP;
            end else begin
               visited_in[stk_rd_ff] = 1'b1;
               cur_in                = stk_rd_ff;
               adj_ctl.rd_en         = 1'b1;
               adj_addr              = stk_rd_ff;
               state_in              = ST_VISIT;
            end
         end
         ST_VISIT: begin
            // the previous vertex goes out now that it is known not to be last
            if (!held_vld_ff || out_free) begin
               if (held_vld_ff) begin
                  rsp_vld_in  = 1'b1;
                  rsp_vtx_in  = VERTEX_W'(held_vtx_ff) + VERTEX_W'(1);
                  rsp_last_in = 1'b0;
                  rsp_ovf_in  = held_ovf_ff;
               end
               held_vld_in = 1'b1;
               held_vtx_in = cur_ff;
               held_ovf_in = ovf_ff;
               row_in      = adj_row;
               scan_in     = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (row_ff[scan_ff] && !visited_ff[scan_ff]) begin
               if (fill_ff != FILL_FULL) begin
                  stk_we  = 1'b1;
                  fill_in = fill_ff + FILL_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (VERTEX_W'(scan_ff) == (n_active - VERTEX_W'(1))) begin
               state_in = ST_POP;
            end else begin
               scan_in = scan_ff + VIDX_W'(1);
            end
         end
         ST_FLUSH: begin
            if (!held_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_vtx_in  = VERTEX_W'(held_vtx_ff) + VERTEX_W'(1);
               rsp_last_in = 1'b1;
               rsp_ovf_in  = held_ovf_ff;
               held_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         vcount_ff   <= VCOUNT_RESET;
         fill_ff     <= '0;
         ovf_ff      <= 1'b0;
         visited_ff  <= '0;
         held_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         vcount_ff   <= vcount_in;
         fill_ff     <= fill_in;
         ovf_ff      <= ovf_in;
         visited_ff  <= visited_in;
         held_vld_ff <= held_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      scan_ff     <= scan_in;
      row_ff      <= row_in;
      cur_ff      <= cur_in;
      dst_ff      <= dst_in;
      held_vtx_ff <= held_vtx_in;
      held_ovf_ff <= held_ovf_in;
      rsp_vtx_ff  <= rsp_vtx_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

endmodule

`default_nettype wire

// ===== sim/adjacency_matrix_dfs_engine_test.sv =====
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_engine_test
// Self-checking bench for the depth-first search engine: a short table of
// directed commands, then phases of random graph building and searches under
// different vertex counts and handshake idling, each visit compared with an
// in-bench search of the same graph or with a visit typed in the table.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_engine_test
   import amdfs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_V          = DEF_MAX_VERTICES;
   localparam int STACK_CAP      = DEF_STACK_DEPTH;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NPLAN          = 20;
   localparam int NPHASE         = 10;
   localparam int ITEMS_PER_PHASE = 10;
   localparam int HOLD_PHASE     = 7;
   localparam int PAUSE_PHASE    = 4;
   localparam int HOLD_CYCLES    = 3000;
   // margin before a vertex count write; the last visit leaves only once the search is done
   localparam int SETTLE_CYCLES  = 8192;
   localparam int CYCLE_LIMIT    = 4_000_000;

   typedef struct packed {
      logic [6:0] vertex;
      logic       last;
      logic       ovf;
   } visit_type;

   // n_typed: -1 checked against the search model, 0 no visit, 1 one lone visit
   typedef struct {
      logic [1:0] op;
      logic [6:0] src;
      logic [6:0] dst;
      int         n_typed;
      logic [6:0] v_typed;
   } step_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;

   // search model state
   logic [MAX_V-1:0] adj_rows [MAX_V];
   logic [MAX_V-1:0] seen_marks;
   logic [5:0]       pend_stack [STACK_CAP];
   int               pend_fill;
   logic             ovf_seen;
   logic [6:0]       vcount;

   visit_type    expected_visits [$];
   step_row_type plan [NPLAN];
   int           phase_vc [NPHASE];

   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   bit  hold_armed = 1'b0;
   bit  hold_taken = 1'b0;
   int  hold_left = 0;
   int  fail_count = 0;
   int  visits_checked = 0;
   int  commands_sent = 0;
   int  cycle_count = 0;

   adjacency_matrix_dfs_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d visits outstanding",
                  cycle_count, expected_visits.size());
         $display("status: fail");
         $finish;
      end
   end

   // result side: random back-pressure, plus one long hold-off
   always @(posedge clock) begin
      if (hold_armed && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      visit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_visits.size() == 0) begin
            $error("visit with none expected: vertex %0d last %0b overflow %0b",
                   rsp_tdata[6:0], rsp_tlast, rsp_tuser);
            fail_count++;
         end else begin
            want = expected_visits.pop_front();
            visits_checked++;
            if (rsp_tdata[6:0] !== want.vertex) begin
               $error("visited_vertex: expected %0d, actual %0d", want.vertex, rsp_tdata[6:0]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_visit: expected %0b, actual %0b", want.last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser !== want.ovf) begin
               $error("stack_overflow: expected %0b, actual %0b", want.ovf, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   function automatic logic [15:0] pack_cmd(logic [1:0] op, logic [6:0] src, logic [6:0] dst);
      return {dst, src, op};
   endfunction

   function automatic int active_vertices();
      return (vcount > MAX_V) ? MAX_V : int'(vcount);
   endfunction

   task automatic push_pending(int idx);
      if (pend_fill < STACK_CAP) begin
         pend_stack[pend_fill] = idx[5:0];
         pend_fill++;
      end else begin
         ovf_seen = 1'b1;
      end
   endtask

   task automatic dfs_predict(input logic [15:0] word, output visit_type found [$]);
      logic [6:0] src;
      logic [6:0] dst;
      int         n;
      int         u;
      visit_type  v;
      found = {};
      src = word[8:2];
      dst = word[15:9];
      n = active_vertices();
      case (word[1:0])
         CMD_CLEAR: begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
         end
         CMD_ADD_EDGE: begin
            if (src >= 1 && src <= n && dst >= 1 && dst <= n)
               adj_rows[src-1][dst-1] = 1'b1;
         end
         CMD_SEARCH: begin
            seen_marks = '0;
            ovf_seen = 1'b0;
            pend_fill = 0;
            if (src >= 1 && src <= n) begin
               push_pending(src - 1);
               while (pend_fill > 0) begin
                  pend_fill--;
                  u = pend_stack[pend_fill];
                  if (seen_marks[u]) continue;
                  seen_marks[u] = 1'b1;
                  v.vertex = 7'(u + 1);
                  v.last   = 1'b0;
                  v.ovf    = ovf_seen;
                  found.push_back(v);
                  for (int i = 0; i < n; i++) begin
                     if (adj_rows[u][i] && !seen_marks[i]) push_pending(i);
                  end
               end
               if (found.size() > 0) found[found.size()-1].last = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   // offer one command, idling first at the sender's rate; valid stays high after
   task automatic send_command(input logic [15:0] word, output visit_type found [$]);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      commands_sent++;
      dfs_predict(word, found);
   endtask

   task automatic drain_visits();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_visits.size() != 0) @(posedge clock);
   endtask

   task automatic write_vcount(logic [6:0] value);
      drain_visits();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      vcount = value;
   endtask

   function automatic logic [15:0] random_command(int n);
      int pick;
      int top;
      pick = $urandom_range(0, 99);
      top  = (n < 1) ? MAX_V : n;
      if (pick < 6)
         return pack_cmd(CMD_CLEAR, 7'($urandom), 7'($urandom));
      else if (pick < 55)
         return pack_cmd(CMD_ADD_EDGE, 7'($urandom_range(1, top)), 7'($urandom_range(1, top)));
      else if (pick < 85)
         return pack_cmd(CMD_SEARCH, 7'($urandom_range(1, top)), 7'($urandom));
      else if (pick < 92)
         return pack_cmd(OP_UNUSED, 7'($urandom), 7'($urandom));
      else
         return 16'($urandom);
   endfunction

   initial begin
      visit_type   found [$];
      logic [15:0] word;
      int          n_eff;

      foreach (adj_rows[i]) adj_rows[i] = '0;
      seen_marks = '0;
      pend_fill  = 0;
      ovf_seen   = 1'b0;
      vcount     = VCOUNT_RESET;

      plan = '{
         '{CMD_SEARCH,   7'd1,   7'd0,   1,  7'd1},   // empty graph: start alone
         '{CMD_SEARCH,   7'd64,  7'd127, 1,  7'd64},
         '{CMD_SEARCH,   7'd0,   7'd0,   0,  7'd0},   // start below range
         '{CMD_SEARCH,   7'd127, 7'd0,   0,  7'd0},
         '{CMD_SEARCH,   7'd65,  7'd0,   0,  7'd0},
         '{OP_UNUSED,    7'd127, 7'd127, 0,  7'd0},
         '{CMD_ADD_EDGE, 7'd1,   7'd64,  0,  7'd0},
         '{CMD_ADD_EDGE, 7'd64,  7'd1,   0,  7'd0},
         '{CMD_ADD_EDGE, 7'd0,   7'd5,   0,  7'd0},   // tail out of range
         '{CMD_ADD_EDGE, 7'd5,   7'd127, 0,  7'd0},   // head out of range
         '{CMD_ADD_EDGE, 7'd1,   7'd2,   0,  7'd0},
         '{CMD_ADD_EDGE, 7'd1,   7'd3,   0,  7'd0},
         '{CMD_ADD_EDGE, 7'd2,   7'd4,   0,  7'd0},
         '{CMD_ADD_EDGE, 7'd3,   7'd4,   0,  7'd0},
         '{CMD_SEARCH,   7'd1,   7'd0,   -1, 7'd0},
         '{CMD_ADD_EDGE, 7'd64,  7'd64,  0,  7'd0},   // self loop
         '{CMD_SEARCH,   7'd64,  7'd0,   -1, 7'd0},
         '{CMD_CLEAR,    7'd127, 7'd127, 0,  7'd0},
         '{CMD_SEARCH,   7'd1,   7'd0,   1,  7'd1},
         '{CMD_SEARCH,   7'd64,  7'd0,   1,  7'd64}
      };
      phase_vc = '{0, 5, 127, 9, 1, 12, 64, 6, 100, 16};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      req_idle_pct = 32;
      rsp_idle_pct = 81;
      for (int r = 0; r < NPLAN; r++) begin
         word = pack_cmd(plan[r].op, plan[r].src, plan[r].dst);
         send_command(word, found);
         if (plan[r].n_typed < 0)
            foreach (found[j]) expected_visits.push_back(found[j]);
         else if (plan[r].n_typed == 1)
            expected_visits.push_back('{plan[r].v_typed, 1'b1, 1'b0});
      end

      for (int p = 0; p < NPHASE; p++) begin
         if (p == 4) begin
            req_idle_pct = 81;
            rsp_idle_pct = 32;
         end
         if (p == 7) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_vcount(7'(phase_vc[p]));
         n_eff = active_vertices();
         if (p == HOLD_PHASE) begin
            // results pile up behind the stalled receiver while commands keep coming
            hold_armed = 1'b1;
            repeat (2) begin
               send_command(pack_cmd(CMD_SEARCH, 7'd1, 7'd0), found);
               foreach (found[j]) expected_visits.push_back(found[j]);
            end
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (p == PAUSE_PHASE && k == 6) drain_visits();
            send_command(random_command(n_eff), found);
            foreach (found[j]) expected_visits.push_back(found[j]);
         end
      end

      drain_visits();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d commands over %0d vertex counts (0, 1, above the maximum, full range)",
               commands_sent, NPHASE + 1);
      $display("%0d visits checked, one long result stall, %0d cycles", visits_checked,
               cycle_count);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
